// ===== sv/pif_pkg.sv =====
// Shared types, constants and helpers for the printf integer formatter.
// Used by the digit unit, the character selector and the top level; no dependencies of its own.
package pif_pkg;

  localparam int DIGIT_BUFFER = 32;
  localparam int MAX_FIELD    = 64;

  // character counts and layout boundaries (MAX_FIELD never exceeds 64)
  localparam int CNT_W = 7;

  // conversion kinds
  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_OCTU = 3'd3;
  localparam logic [2:0] CONV_HEXL = 3'd4;
  localparam logic [2:0] CONV_HEXU = 3'd5;

  // radix codes for the digit unit
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // ASCII
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef struct packed {
    logic       start;
    logic [1:0] radix;
  } dig_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dig_stat_t;

  // text layout: chars [0,b1) blanks, [b1,b2) prefix, [b2,b3) zeros,
  // [b3,b4) digits, [b4,total) blanks
  typedef struct packed {
    logic [CNT_W-1:0] b1;
    logic [CNT_W-1:0] b2;
    logic [CNT_W-1:0] b3;
    logic [CNT_W-1:0] b4;
    logic [CNT_W-1:0] total;
    logic [7:0]       pre0;
    logic [7:0]       pre1;
    logic [7:0]       pre2;
    logic             upper;
  } layout_t;

  function automatic logic [7:0] sym_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = CH_A_UP + {4'd0, d} - 8'd10;
    end else begin
      c = CH_A_LO + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== sv/pif_digit_unit.sv =====
// Shared digit unit: double-dabble steps for decimal, shift-out steps for
// octal and hex, into a register digit buffer. Depends on pif_pkg.
module pif_digit_unit #(
  parameter int DIGIT_BUFFER = pif_pkg::DIGIT_BUFFER,
  localparam int NDW = $clog2(DIGIT_BUFFER + 1),
  localparam int DIW = $clog2(DIGIT_BUFFER)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pif_pkg::dig_ctrl_t  ctrl_i,
  input  logic [63:0]         mag_i,
  input  logic [DIW-1:0]      rd_idx_i,
  output pif_pkg::dig_stat_t  stat_o,
  output logic [NDW-1:0]      ndig_o,
  output logic [3:0]          rd_digit_o
);

  logic [3:0]     dig_r   [DIGIT_BUFFER];
  logic [3:0]     dig_nxt [DIGIT_BUFFER];
  logic [3:0]     adj     [DIGIT_BUFFER];
  logic [3:0]     shl     [DIGIT_BUFFER];
  logic [DIGIT_BUFFER-1:0] nz;
  logic [63:0]    mag_r, mag_nxt;
  logic [NDW-1:0] ndig_r, ndig_nxt;
  logic [5:0]     step_r, step_nxt;
  logic [1:0]     radix_r, radix_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           room;

  // one dabble step: add 3 to digits of 5 or more, then shift in a bit
  always_comb begin
    for (int k = 0; k < DIGIT_BUFFER; k++) begin
      adj[k] = (dig_r[k] >= 4'd5) ? dig_r[k] + 4'd3 : dig_r[k];
    end
    for (int k = 0; k < DIGIT_BUFFER; k++) begin
      if (k == 0) begin
        shl[k] = {adj[k][2:0], mag_r[63]};
      end else begin
        shl[k] = {adj[k][2:0], adj[k-1][3]};
      end
      nz[k] = |shl[k];
    end
  end

  assign room = (ndig_r < NDW'(DIGIT_BUFFER));

  always_comb begin
    dig_nxt   = dig_r;
    mag_nxt   = mag_r;
    ndig_nxt  = ndig_r;
    step_nxt  = step_r;
    radix_nxt = radix_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (ctrl_i.start) begin
      mag_nxt   = mag_i;
      radix_nxt = ctrl_i.radix;
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      if (ctrl_i.radix == pif_pkg::RADIX_DEC) begin
        for (int k = 0; k < DIGIT_BUFFER; k++) begin
          dig_nxt[k] = 4'd0;
        end
        ndig_nxt = NDW'(1);
      end else begin
        ndig_nxt = '0;
      end
    end else if (busy_r) begin
      if (radix_r == pif_pkg::RADIX_DEC) begin
        dig_nxt  = shl;
        mag_nxt  = {mag_r[62:0], 1'b0};
        step_nxt = step_r + 6'd1;
        // value grows by at most one digit per step
        if (room && nz[ndig_r[DIW-1:0]]) begin
          ndig_nxt = ndig_r + NDW'(1);
        end
        if (step_r == 6'd63) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end else begin
        if (room) begin
          if (radix_r == pif_pkg::RADIX_OCT) begin
            dig_nxt[ndig_r[DIW-1:0]] = {1'b0, mag_r[2:0]};
          end else begin
            dig_nxt[ndig_r[DIW-1:0]] = mag_r[3:0];
          end
          ndig_nxt = ndig_r + NDW'(1);
        end
        if (radix_r == pif_pkg::RADIX_OCT) begin
          mag_nxt = {3'd0, mag_r[63:3]};
        end else begin
          mag_nxt = {4'd0, mag_r[63:4]};
        end
        if (mag_nxt == 64'd0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      ndig_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
      ndig_r <= ndig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    mag_r   <= mag_nxt;
    radix_r <= radix_nxt;
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign ndig_o      = ndig_r;
  assign rd_digit_o  = dig_r[rd_idx_i];

endmodule

// ===== sv/pif_char_sel.sv =====
// Character selector: maps a text position to its ASCII character using the
// registered layout and the digit buffer read port. Depends on pif_pkg.
module pif_char_sel #(
  parameter int DIGIT_BUFFER = pif_pkg::DIGIT_BUFFER,
  localparam int DIW = $clog2(DIGIT_BUFFER)
) (
  input  pif_pkg::layout_t           lay_i,
  input  logic [pif_pkg::CNT_W-1:0]  pos_i,
  input  logic [3:0]                 digit_i,
  output logic [DIW-1:0]             rd_idx_o,
  output logic [7:0]                 char_o
);

  logic [pif_pkg::CNT_W-1:0] off;
  logic [pif_pkg::CNT_W-1:0] didx;

  assign off      = pos_i - lay_i.b1;
  assign didx     = lay_i.b4 - pos_i - pif_pkg::CNT_W'(1);
  assign rd_idx_o = didx[DIW-1:0];

  always_comb begin
    if (pos_i < lay_i.b1) begin
      char_o = pif_pkg::CH_SPACE;
    end else if (pos_i < lay_i.b2) begin
      case (off[1:0])
        2'd0:    char_o = lay_i.pre0;
        2'd1:    char_o = lay_i.pre1;
        default: char_o = lay_i.pre2;
      endcase
    end else if (pos_i < lay_i.b3) begin
      char_o = pif_pkg::CH_ZERO;
    end else if (pos_i < lay_i.b4) begin
      char_o = pif_pkg::sym_char(digit_i, lay_i.upper);
    end else begin
      char_o = pif_pkg::CH_SPACE;
    end
  end

endmodule

// ===== sv/printf_integer_formatter_unit.sv =====
// Top level of the printf-style integer formatter: sequencer, layout math
// and output register. Uses pif_pkg, pif_digit_unit and pif_char_sel.
//
// One 64-bit integer goes in per input transfer and comes out as its
// printf-style text, one ASCII character per output transfer, tlast on the
// final one. Digits are built by one shared digit unit: decimal kinds run
// 64 double-dabble steps, octal and hex take one step per digit (1 to 22
// for octal, 1 to 16 for hex). The S_SIZE state then sizes the text, at
// most MAX_FIELD characters, and the characters leave at one per cycle
// through the output register while out_tready is high. in_tready is
// high only while the sequencer is idle; it rises as the last character
// is loaded, so the next item's digit work overlaps the drain of that
// character.
module printf_integer_formatter_unit #(
  parameter int DIGIT_BUFFER = pif_pkg::DIGIT_BUFFER,
  parameter int MAX_FIELD    = pif_pkg::MAX_FIELD
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, low bit up: value[63:0], left_justify, force_sign,
  // blank_sign, alternate_form, zero_pad, field_width[6:0],
  // min_digits[5:0], 6 zero bits
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,
  // in_tuser: conversion[2:0]
  input  logic [2:0]  in_tuser,
  // out_tdata: out_char[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  // out_tlast: last_char
  output logic        out_tlast
);

  localparam int NDW   = $clog2(DIGIT_BUFFER + 1);
  localparam int DIW   = $clog2(DIGIT_BUFFER);
  localparam int CW    = pif_pkg::CNT_W;
  localparam int PMAX  = MAX_FIELD - 3;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIGITS = 2'd1;
  localparam logic [1:0] S_SIZE   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  // input field views
  logic [63:0] f_value;
  logic        f_left, f_plus, f_blank, f_alt, f_zpad;
  logic [6:0]  f_width;
  logic [5:0]  f_prec;

  assign f_value = in_tdata[63:0];
  assign f_left  = in_tdata[64];
  assign f_plus  = in_tdata[65];
  assign f_blank = in_tdata[66];
  assign f_alt   = in_tdata[67];
  assign f_zpad  = in_tdata[68];
  assign f_width = in_tdata[75:69];
  assign f_prec  = in_tdata[81:76];

  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // per-item captured format
  logic       left_r, zpad_r, upper_r;
  logic [6:0] w_r;
  logic [5:0] p_r;
  logic [1:0] npre_r;
  logic [7:0] pre0_r, pre1_r, pre2_r;

  logic       neg, upper;
  logic [1:0] radix;
  logic [63:0] mag;
  logic [1:0] npre;
  logic [7:0] pre0, pre1, pre2;
  logic [6:0] w_sat;
  logic [5:0] p_sat;

  always_comb begin
    if (in_tuser inside {pif_pkg::CONV_OCT, pif_pkg::CONV_OCTU}) begin
      radix = pif_pkg::RADIX_OCT;
    end else if (in_tuser inside {pif_pkg::CONV_HEXL, pif_pkg::CONV_HEXU}) begin
      radix = pif_pkg::RADIX_HEX;
    end else begin
      radix = pif_pkg::RADIX_DEC;
    end
    upper = (in_tuser == pif_pkg::CONV_OCTU) || (in_tuser == pif_pkg::CONV_HEXU);
    neg   = (in_tuser == pif_pkg::CONV_SDEC) && f_value[63];
    mag   = neg ? (64'd0 - f_value) : f_value;

    // prefix in print order: sign, then 0 or 0x/0X
    pre0 = pif_pkg::CH_SPACE;
    pre1 = pif_pkg::CH_SPACE;
    pre2 = pif_pkg::CH_SPACE;
    npre = 2'd0;
    if (neg || f_plus || f_blank) begin
      pre0 = neg ? pif_pkg::CH_MINUS : (f_plus ? pif_pkg::CH_PLUS : pif_pkg::CH_SPACE);
      npre = 2'd1;
    end
    if (f_alt && (radix != pif_pkg::RADIX_DEC)) begin
      if (npre == 2'd0) begin
        pre0 = pif_pkg::CH_ZERO;
        pre1 = upper ? pif_pkg::CH_X_UP : pif_pkg::CH_X_LO;
      end else begin
        pre1 = pif_pkg::CH_ZERO;
        pre2 = upper ? pif_pkg::CH_X_UP : pif_pkg::CH_X_LO;
      end
      npre = npre + ((radix == pif_pkg::RADIX_HEX) ? 2'd2 : 2'd1);
    end

    w_sat = (f_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : f_width;
    p_sat = (f_prec > 6'(PMAX)) ? 6'(PMAX) : f_prec;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_r  <= f_left;
      zpad_r  <= f_zpad;
      upper_r <= upper;
      w_r     <= w_sat;
      p_r     <= p_sat;
      npre_r  <= npre;
      pre0_r  <= pre0;
      pre1_r  <= pre1;
      pre2_r  <= pre2;
    end
  end

  // shared digit unit
  pif_pkg::dig_ctrl_t dig_ctrl;
  pif_pkg::dig_stat_t dig_stat;
  logic [NDW-1:0]     ndig;
  logic [DIW-1:0]     rd_idx;
  logic [3:0]         rd_digit;

  assign dig_ctrl.start = accept;
  assign dig_ctrl.radix = radix;

  pif_digit_unit #(
    .DIGIT_BUFFER (DIGIT_BUFFER)
  ) u_digit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (dig_ctrl),
    .mag_i      (mag),
    .rd_idx_i   (rd_idx),
    .stat_o     (dig_stat),
    .ndig_o     (ndig),
    .rd_digit_o (rd_digit)
  );

  // layout sizing in S_SIZE, once the digit count is known
  pif_pkg::layout_t lay_r, lay_nxt;
  logic [CW:0] nd8, np8, pp8, ww8, nz0, len, nzer, nbl;
  logic [CW:0] b1, b2, b3, b4, tot;

  always_comb begin
    nd8  = (CW+1)'(ndig);
    np8  = (CW+1)'(npre_r);
    pp8  = (CW+1)'(p_r);
    ww8  = (CW+1)'(w_r);
    nz0  = (pp8 > nd8) ? (pp8 - nd8) : '0;
    len  = np8 + nz0 + nd8;
    nzer = nz0;
    nbl  = '0;
    if (ww8 > len) begin
      // zero padding with a width takes over the precision zeros
      if (zpad_r && !left_r) begin
        nzer = ww8 - np8 - nd8;
      end else begin
        nbl = ww8 - len;
      end
    end
    b1  = left_r ? '0 : nbl;
    b2  = b1 + np8;
    b3  = b2 + nzer;
    b4  = b3 + nd8;
    tot = b4 + (left_r ? nbl : '0);
    if (tot > (CW+1)'(MAX_FIELD)) begin
      tot = (CW+1)'(MAX_FIELD);
    end
    lay_nxt.b1    = b1[CW-1:0];
    lay_nxt.b2    = b2[CW-1:0];
    lay_nxt.b3    = b3[CW-1:0];
    lay_nxt.b4    = b4[CW-1:0];
    lay_nxt.total = tot[CW-1:0];
    lay_nxt.pre0  = pre0_r;
    lay_nxt.pre1  = pre1_r;
    lay_nxt.pre2  = pre2_r;
    lay_nxt.upper = upper_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SIZE) begin
      lay_r <= lay_nxt;
    end
  end

  // character emission
  logic [CW-1:0] pos_r, pos_nxt;
  logic [7:0]    ch;
  logic          load, is_last;

  pif_char_sel #(
    .DIGIT_BUFFER (DIGIT_BUFFER)
  ) u_char_sel (
    .lay_i    (lay_r),
    .pos_i    (pos_r),
    .digit_i  (rd_digit),
    .rd_idx_o (rd_idx),
    .char_o   (ch)
  );

  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic          out_last_r;

  assign load    = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign is_last = ((pos_r + CW'(1)) == lay_r.total);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (dig_stat.done) begin
          state_nxt = S_SIZE;
        end
      end
      S_SIZE: begin
        pos_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (load) begin
          pos_nxt = pos_r + CW'(1);
          if (is_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= ch;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/pif_checker.sv =====
// Port-level checker for printf_integer_formatter_unit and its bind.
// Depends only on the top level's ports.
module pif_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled output transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accepting an item");

  // a non-final character means the text is still going out
  a_no_ready_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("ready while text of an item is pending");

  // every character is printable ASCII
  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7] && (out_tdata >= 8'h20))
    else $error("non-printable character");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind printf_integer_formatter_unit pif_checker u_pif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
